// ===== design/assert_macros.svh =====
// Assertion macros used by the stack top module bounded_lifo_stack_unit.
// Each macro expects i_clk and i_rst_n in scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset
`define BLS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("stack check failed");

// Same-cycle implication
`define BLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stack check failed");

// Next-cycle implication
`define BLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stack check failed");

`endif

// ===== design/bls_pkg.sv =====
// Shared types and constants of the bounded LIFO stack.
// No dependencies; used by every module of the block.
`default_nettype none

package bls_pkg;

    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 6;
    localparam int CAP_EXT_W = 7;
    localparam int DEPTH_DEF = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DMIN  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UDF = 2'd2;

    localparam logic signed [WORD_W-1:0] WORD_FAIL = -32'sd1;
    localparam logic signed [WORD_W-1:0] WORD_NONE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic                     full_res;
        logic                     empty_res;
        logic                     last;
    } t_out_beat;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic init;
        logic upd;
    } t_min_ctl;

endpackage

`default_nettype wire

// ===== design/bounded_lifo_stack_unit.sv =====
// Bounded LIFO stack of signed 32-bit words with a configurable capacity.
// Input channel i_in_valid / o_in_stall carries one beat: an operation and a word.
// Output channel o_out_valid / i_out_stall returns result beats from an output
// register, so the block takes the next beat while a result still waits there.
// Push and pop go straight to their result; peek first reads the top word. Drain-out
// reads and emits each stored word in turn, top word first, with last on the final
// beat and nothing on an empty stack. Drain-min walks the words bottom up through
// one compare unit. The word store has a single read port. Codes 5 to 7 are dropped
// without a result.
// i_cfg_we writes the capacity (clamped to 1..DEPTH) and empties the stack;
// write it only while the block is idle. There is no read-back.
// Synchronous active-low reset empties the stack, sets capacity to 32 and
// clears the output valid flag. While the receiver stalls, the held result stays;
// a sequencer with its next result ready waits, raising o_in_stall until the beat is taken.
// Depends on bls_pkg, bls_mem, bls_min and assert_macros.svh.
`default_nettype none

module bounded_lifo_stack_unit #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire bls_pkg::t_in_beat         i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output bls_pkg::t_out_beat             o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [bls_pkg::CAP_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CAP,
        S_EMIT,
        S_MRD,
        S_MCMP,
        S_MEND
    } t_state;

    t_state                                r_state;
    logic [bls_pkg::CAP_W-1:0]             r_cap;
    logic [CW-1:0]                         r_count;
    logic [AW-1:0]                         r_idx;
    logic [AW-1:0]                         r_last;
    logic [bls_pkg::FUNC_W-1:0]            r_func;
    bls_pkg::t_out_beat                    r_res;
    bls_pkg::t_out_beat                    r_out;
    logic                                  r_out_valid;

    logic [bls_pkg::CAP_EXT_W-1:0]         w_cap_ext;
    logic [bls_pkg::CAP_EXT_W-1:0]         w_cap_clamp;
    logic [CW-1:0]                         w_cap_eff;
    logic [CW-1:0]                         w_cnt_inc;
    logic [CW-1:0]                         w_cnt_dec;
    logic                                  w_full;
    logic                                  w_empty;
    logic                                  w_in_acc;
    logic                                  w_out_free;
    bls_pkg::t_mem_ctl                     w_mem_ctl;
    bls_pkg::t_min_ctl                     w_min_ctl;
    logic signed [bls_pkg::WORD_W-1:0]     w_rdata;
    logic signed [bls_pkg::WORD_W-1:0]     w_min;

    // Clamp capacity to 1..DEPTH
    always_comb begin
        w_cap_ext = {1'b0, r_cap};
        if (r_cap == '0) begin
            w_cap_clamp = bls_pkg::CAP_EXT_W'(1);
        end else if (w_cap_ext > bls_pkg::CAP_EXT_W'(DEPTH)) begin
            w_cap_clamp = bls_pkg::CAP_EXT_W'(DEPTH);
        end else begin
            w_cap_clamp = w_cap_ext;
        end
        w_cap_eff = w_cap_clamp[CW-1:0];
    end

    assign w_cnt_inc  = r_count + CW'(1);
    assign w_cnt_dec  = r_count - CW'(1);
    assign w_full     = (r_count == w_cap_eff);
    assign w_empty    = (r_count == '0);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Store port and compare unit control
    assign w_mem_ctl.we  = w_in_acc && (i_in.func == bls_pkg::FUNC_PUSH) && !w_full;
    assign w_mem_ctl.re  = (r_state == S_RD) || (r_state == S_MRD);
    assign w_min_ctl.init = w_in_acc && (i_in.func == bls_pkg::FUNC_DMIN);
    assign w_min_ctl.upd  = (r_state == S_MCMP);

    bls_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    bls_min u_min (
        .i_clk  (i_clk),
        .i_ctl  (w_min_ctl),
        .i_word (w_rdata),
        .o_min  (w_min)
    );

    // Sequencer, stack state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_cap       <= bls_pkg::CAP_RESET;
        end else begin
            // Drop the output beat once taken
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func          <= i_in.func;
                        r_res.data      <= '0;
                        r_res.status    <= bls_pkg::ST_OK;
                        r_res.full_res  <= w_full;
                        r_res.empty_res <= w_empty;
                        r_res.last      <= 1'b1;
                        unique case (i_in.func)
                            bls_pkg::FUNC_PUSH: begin
                                if (w_full) begin
                                    r_res.status <= bls_pkg::ST_OVF;
                                end else begin
                                    r_count         <= w_cnt_inc;
                                    r_res.full_res  <= (w_cnt_inc == w_cap_eff);
                                    r_res.empty_res <= 1'b0;
                                end
                                r_state <= S_EMIT;
                            end
                            bls_pkg::FUNC_POP: begin
                                if (w_empty) begin
                                    r_res.status <= bls_pkg::ST_UDF;
                                end else begin
                                    r_count         <= w_cnt_dec;
                                    r_res.full_res  <= 1'b0;
                                    r_res.empty_res <= (w_cnt_dec == '0);
                                end
                                r_state <= S_EMIT;
                            end
                            bls_pkg::FUNC_PEEK: begin
                                if (w_empty) begin
                                    r_res.data   <= bls_pkg::WORD_FAIL;
                                    r_res.status <= bls_pkg::ST_UDF;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_idx   <= w_cnt_dec[AW-1:0];
                                    r_state <= S_RD;
                                end
                            end
                            bls_pkg::FUNC_DRAIN: begin
                                // Empty stack gives no beat at all
                                if (!w_empty) begin
                                    r_count         <= '0;
                                    r_idx           <= w_cnt_dec[AW-1:0];
                                    r_res.full_res  <= 1'b0;
                                    r_res.empty_res <= 1'b1;
                                    r_state         <= S_RD;
                                end
                            end
                            bls_pkg::FUNC_DMIN: begin
                                r_count         <= '0;
                                r_res.full_res  <= 1'b0;
                                r_res.empty_res <= 1'b1;
                                if (w_empty) begin
                                    r_res.data <= bls_pkg::WORD_NONE;
                                    r_state    <= S_EMIT;
                                end else begin
                                    r_idx   <= '0;
                                    r_last  <= w_cnt_dec[AW-1:0];
                                    r_state <= S_MRD;
                                end
                            end
                            default: begin
                                // Unused codes: drop the beat
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_res.data <= w_rdata;
                    r_res.last <= (r_func != bls_pkg::FUNC_DRAIN) || (r_idx == '0);
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        if ((r_func == bls_pkg::FUNC_DRAIN) && (r_idx != '0)) begin
                            r_idx   <= r_idx - AW'(1);
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MRD: begin
                    r_state <= S_MCMP;
                end
                S_MCMP: begin
                    if (r_idx == r_last) begin
                        r_state <= S_MEND;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_MRD;
                    end
                end
                S_MEND: begin
                    r_res.data <= w_min;
                    r_state    <= S_EMIT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Capacity write empties the stack
            if (i_cfg_we) begin
                r_cap   <= i_cfg_data;
                r_count <= '0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `BLS_ASSERT_ALWAYS(a_count_within_cap, r_count <= w_cap_eff)
    `BLS_ASSERT_IMPL(a_nonlast_only_drain, r_out_valid && !r_out.last, r_func == bls_pkg::FUNC_DRAIN)
    `BLS_ASSERT_NEXT(a_push_grows, w_mem_ctl.we && !i_cfg_we, r_count == $past(w_cnt_inc))
    `BLS_ASSERT_IMPL(a_min_walk_empty, r_state == S_MRD || r_state == S_MCMP || r_state == S_MEND, r_count == '0)

endmodule

`default_nettype wire

// ===== design/bls_mem.sv =====
// Word store of the stack: one write port, one read port, registered read data.
// Depends on bls_pkg for the word width and the port control struct.
`default_nettype none

module bls_mem #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                             i_clk,
    input  wire bls_pkg::t_mem_ctl                i_ctl,
    input  wire logic [AW-1:0]                    i_waddr,
    input  wire logic signed [bls_pkg::WORD_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                    i_raddr,
    output logic signed [bls_pkg::WORD_W-1:0]     o_rdata
);

    logic signed [bls_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic signed [bls_pkg::WORD_W-1:0] r_rdata;

    // Write a pushed word
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one word, data valid the next cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/bls_min.sv =====
// Running-minimum unit: one signed compare and select, reused for every stored word.
// Depends on bls_pkg for the word width, the empty-minimum constant and the control struct.
`default_nettype none

module bls_min (
    input  wire logic                              i_clk,
    input  wire bls_pkg::t_min_ctl                 i_ctl,
    input  wire logic signed [bls_pkg::WORD_W-1:0] i_word,
    output logic signed [bls_pkg::WORD_W-1:0]      o_min
);

    logic signed [bls_pkg::WORD_W-1:0] r_min;

    // Start from the largest word, then keep the smaller one
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_min <= bls_pkg::WORD_NONE;
        end else if (i_ctl.upd && (i_word < r_min)) begin
            r_min <= i_word;
        end
    end

    assign o_min = r_min;

endmodule

`default_nettype wire
